// File: design/sme_pkg.sv
// Shared types and codes for the stack machine execute core.
`default_nettype none
package sme_pkg;

    // Program address space; branch targets are ten bits wide to match it.
    localparam int PROGRAM_DEPTH = 1024;

    typedef enum logic [4:0] {
        OP_PSH = 5'd0,  OP_POP = 5'd1,  OP_POR = 5'd2,  OP_ADD = 5'd3,
        OP_SUB = 5'd4,  OP_MUL = 5'd5,  OP_DIV = 5'd6,  OP_MOV = 5'd7,
        OP_CMP = 5'd8,  OP_JMP = 5'd9,  OP_JIE = 5'd10, OP_JNE = 5'd11,
        OP_ALC = 5'd12, OP_FRE = 5'd13, OP_ST  = 5'd14, OP_LD  = 5'd15,
        OP_MSG = 5'd16, OP_HLT = 5'd17
    } t_op;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_HALTED = 3'd1, ST_UNDER = 3'd2,
        ST_OVER = 3'd3, ST_DIVZ = 3'd4, ST_NOCELL = 3'd5
    } t_status;

    localparam logic [1:0] MODE_STACK = 2'd0;
    localparam logic [1:0] MODE_IMM   = 2'd1;

    typedef struct packed {
        logic [4:0]         func;
        logic signed [31:0] imm;
        logic [2:0]         dst_sel;
        logic [2:0]         src_sel;
        logic [1:0]         operand_mode;
        logic [9:0]         jump_target;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic               branch_taken;
        logic [9:0]         branch_target;
        logic               shown_valid;
        logic signed [31:0] shown_value;
    } t_out_item;

    typedef enum logic [1:0] {
        ALU_MUL = 2'd0, ALU_DIV = 2'd1
    } t_alu_op;

    // Start request and done report between sequencer and shared unit.
    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_rsp;

    typedef enum logic [2:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_ALU, S_WAIT, S_OUT
    } t_state;

endpackage
`default_nettype wire

// File: design/sme_alu.sv
// Shared iterative unit: shift-add multiply and restoring signed divide, one bit a cycle.
`default_nettype none
module sme_alu (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sme_pkg::t_alu_req i_req,
    input  wire logic [31:0]     i_a,
    input  wire logic [31:0]     i_b,
    output sme_pkg::t_alu_rsp    o_rsp,
    output logic [31:0]          o_result
);
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [5:0]    r_cnt, n_cnt;
    sme_pkg::t_alu_op r_op, n_op;
    logic [31:0]   r_acc, n_acc;   // product or remainder
    logic [31:0]   r_q, n_q;       // multiplier shift or quotient
    logic [31:0]   r_b, n_b;       // multiplicand or divisor magnitude
    logic          r_neg, n_neg;
    logic [32:0]   trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op  <= n_op;
        r_acc <= n_acc;
        r_q   <= n_q;
        r_b   <= n_b;
        r_neg <= n_neg;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_acc  = r_acc;
        n_q    = r_q;
        n_b    = r_b;
        n_neg  = r_neg;
        trial  = {r_acc, r_q[31]} - {1'b0, r_b};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd32;
            n_op   = i_req.op;
            n_acc  = '0;
            if (i_req.op == sme_pkg::ALU_MUL) begin
                n_q = i_b;
                n_b = i_a;
                n_neg = 1'b0;
            end else begin
                n_q   = i_a[31] ? (32'd0 - i_a) : i_a;
                n_b   = i_b[31] ? (32'd0 - i_b) : i_b;
                n_neg = i_a[31] ^ i_b[31];
            end
        end else if (r_busy) begin
            if (r_op == sme_pkg::ALU_MUL) begin
                // Product modulo 2^32: add shifted multiplicand per multiplier bit.
                n_acc = r_acc + (r_q[0] ? r_b : 32'd0);
                n_q   = {1'b0, r_q[31:1]};
                n_b   = {r_b[30:0], 1'b0};
            end else begin
                if (!trial[32]) begin
                    n_acc = trial[31:0];
                    n_q   = {r_q[30:0], 1'b1};
                end else begin
                    n_acc = {r_acc[30:0], r_q[31]};
                    n_q   = {r_q[30:0], 1'b0};
                end
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result = (r_op == sme_pkg::ALU_MUL) ? r_acc :
                      (r_neg ? (32'd0 - r_q) : r_q);

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without prior busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("start while busy");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 6'd0)
        else $error("busy with zero count");

endmodule
`default_nettype wire

// File: design/stack_machine_execute_core.sv
// Top level: sequencer, stack memory, register file and output register.
// Every instruction reads the top of stack in S_RD1; ADD, SUB, MUL and DIV also read
// the second in S_RD2; MUL and DIV then run on the shared one-bit-a-cycle unit.
// One item at a time: o_in_stall is high from transfer until the result is transferred,
// so a new item waits for the last result; the registered stack read port sets S_RD1.
// Synchronous active-low reset clears depth, registers, flags and halt; no clearing pass.
`default_nettype none
module stack_machine_execute_core #(
    parameter int STACK_DEPTH   = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire sme_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output sme_pkg::t_out_item     o_out_data
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    sme_pkg::t_state r_state, n_state;
    sme_pkg::t_in_item r_item;
    logic [DW-1:0] r_depth, n_depth;
    logic [31:0]   r_regs [5];
    logic [31:0]   n_regs [5];
    logic          r_eq, n_eq, r_cv, n_cv, r_halt, n_halt;
    logic [31:0]   r_cell, n_cell;
    logic [31:0]   r_top, r_sec;
    logic          r_ov, n_ov;
    sme_pkg::t_out_item r_out, n_out;

    logic [31:0]   mem [STACK_DEPTH];
    logic [31:0]   rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    sme_pkg::t_alu_req alu_req;
    sme_pkg::t_alu_rsp alu_rsp;
    logic [31:0]   alu_res;

    logic [31:0]   dst_val, src_val, other;
    logic [9:0]    tgt;
    logic [DW-1:0] dm1;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

    sme_alu u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(alu_req),
        .i_a(r_sec), .i_b(r_top), .o_rsp(alu_rsp), .o_result(alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sme_pkg::S_IDLE;
            r_depth <= '0;
            for (int i = 0; i < 5; i++) r_regs[i] <= '0;
            r_eq <= 1'b0;
            r_cv <= 1'b0;
            r_cell <= '0;
            r_halt <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            for (int i = 0; i < 5; i++) r_regs[i] <= n_regs[i];
            r_eq <= n_eq;
            r_cv <= n_cv;
            r_cell <= n_cell;
            r_halt <= n_halt;
            r_ov <= n_ov;
        end
        if (r_state == sme_pkg::S_IDLE && i_in_valid) r_item <= i_in_data;
        if (r_state == sme_pkg::S_RD1) r_top <= rd_data;
        if (r_state == sme_pkg::S_RD2) begin
            r_sec <= rd_data;
        end
        r_out <= n_out;
    end

    assign dm1 = r_depth - DW'(1);
    assign dst_val = (r_item.dst_sel < 3'd5) ? r_regs[r_item.dst_sel] : 32'd0;
    assign src_val = (r_item.src_sel < 3'd5) ? r_regs[r_item.src_sel] : 32'd0;
    assign tgt = 10'(32'(r_item.jump_target) % sme_pkg::PROGRAM_DEPTH);

    always_comb begin
        priority case (r_item.operand_mode)
            sme_pkg::MODE_STACK: other = r_top;
            sme_pkg::MODE_IMM:   other = r_item.imm;
            default:             other = src_val;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_depth = r_depth;
        for (int i = 0; i < 5; i++) n_regs[i] = r_regs[i];
        n_eq = r_eq;
        n_cv = r_cv;
        n_cell = r_cell;
        n_halt = r_halt;
        n_ov = r_ov;
        n_out = r_out;
        rd_addr = dm1[AW-1:0];
        wr_en = 1'b0;
        wr_addr = r_depth[AW-1:0];
        wr_data = '0;
        alu_req.start = 1'b0;
        alu_req.op = sme_pkg::ALU_MUL;
        unique case (r_state)
            sme_pkg::S_IDLE: begin
                if (i_in_valid) n_state = sme_pkg::S_RD1;
            end
            sme_pkg::S_RD1: begin
                // Address of the top was presented last cycle; now present the second.
                rd_addr = AW'(r_depth - DW'(2));
                n_state = (r_item.func == sme_pkg::OP_ADD || r_item.func == sme_pkg::OP_SUB
                        || r_item.func == sme_pkg::OP_MUL || r_item.func == sme_pkg::OP_DIV)
                        ? sme_pkg::S_RD2 : sme_pkg::S_EXEC;
            end
            sme_pkg::S_RD2: n_state = sme_pkg::S_EXEC;
            sme_pkg::S_EXEC: begin
                n_out = '0;
                n_out.status = sme_pkg::ST_OK;
                n_state = sme_pkg::S_OUT;
                if (r_halt) begin
                    n_out.status = sme_pkg::ST_HALTED;
                end else begin
                    unique case (r_item.func)
                        sme_pkg::OP_PSH, sme_pkg::OP_POR, sme_pkg::OP_LD: begin
                            if (32'(r_depth) >= STACK_DEPTH)
                                n_out.status = sme_pkg::ST_OVER;
                            else if (r_item.func == sme_pkg::OP_LD && !r_cv)
                                n_out.status = sme_pkg::ST_NOCELL;
                            else begin
                                wr_en = 1'b1;
                                n_depth = r_depth + DW'(1);
                                if (r_item.func == sme_pkg::OP_PSH) wr_data = r_item.imm;
                                else if (r_item.func == sme_pkg::OP_LD) wr_data = r_cell;
                                else begin
                                    wr_data = dst_val;
                                    if (r_item.dst_sel < 3'd5) n_regs[r_item.dst_sel] = '0;
                                end
                            end
                        end
                        sme_pkg::OP_POP: begin
                            if (r_depth == '0) n_out.status = sme_pkg::ST_UNDER;
                            else begin
                                n_regs[2] = r_top;
                                n_depth = dm1;
                            end
                        end
                        sme_pkg::OP_ADD, sme_pkg::OP_SUB,
                        sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
                            if (r_depth < DW'(2)) n_out.status = sme_pkg::ST_UNDER;
                            else if (r_item.func == sme_pkg::OP_DIV && r_top == '0)
                                n_out.status = sme_pkg::ST_DIVZ;
                            else if (r_item.func == sme_pkg::OP_ADD ||
                                     r_item.func == sme_pkg::OP_SUB) begin
                                wr_en = 1'b1;
                                wr_addr = AW'(r_depth - DW'(2));
                                wr_data = (r_item.func == sme_pkg::OP_ADD) ?
                                          r_sec + r_top : r_sec - r_top;
                                n_depth = dm1;
                            end else begin
                                alu_req.start = 1'b1;
                                alu_req.op = (r_item.func == sme_pkg::OP_MUL) ?
                                             sme_pkg::ALU_MUL : sme_pkg::ALU_DIV;
                                n_state = sme_pkg::S_ALU;
                            end
                        end
                        sme_pkg::OP_MOV: begin
                            if (r_item.operand_mode == sme_pkg::MODE_STACK) begin
                                if (r_depth == '0) n_out.status = sme_pkg::ST_UNDER;
                                else begin
                                    n_depth = dm1;
                                    if (r_item.dst_sel < 3'd5) n_regs[r_item.dst_sel] = other;
                                end
                            end else if (r_item.dst_sel < 3'd5)
                                n_regs[r_item.dst_sel] = other;
                        end
                        sme_pkg::OP_CMP: begin
                            if (r_item.operand_mode == sme_pkg::MODE_STACK && r_depth == '0)
                                n_out.status = sme_pkg::ST_UNDER;
                            else n_eq = (dst_val == other);
                        end
                        sme_pkg::OP_JMP, sme_pkg::OP_JIE, sme_pkg::OP_JNE: begin
                            if (r_item.func == sme_pkg::OP_JMP ||
                                (r_item.func == sme_pkg::OP_JIE && r_eq) ||
                                (r_item.func == sme_pkg::OP_JNE && !r_eq)) begin
                                n_out.branch_taken = 1'b1;
                                n_out.branch_target = tgt;
                            end
                        end
                        sme_pkg::OP_ALC: begin
                            n_cv = 1'b1;
                            n_cell = '0;
                        end
                        sme_pkg::OP_FRE: n_cv = 1'b0;
                        sme_pkg::OP_ST: begin
                            if (r_depth == '0) n_out.status = sme_pkg::ST_UNDER;
                            else if (!r_cv) n_out.status = sme_pkg::ST_NOCELL;
                            else begin
                                n_cell = r_top;
                                n_depth = dm1;
                            end
                        end
                        sme_pkg::OP_MSG: begin
                            if (r_depth == '0) n_out.status = sme_pkg::ST_UNDER;
                            else begin
                                n_out.shown_valid = 1'b1;
                                n_out.shown_value = r_top;
                            end
                        end
                        default: n_out.status = sme_pkg::ST_HALTED;
                    endcase
                    if (n_out.status != sme_pkg::ST_OK) n_halt = 1'b1;
                end
                if (n_state == sme_pkg::S_OUT) n_ov = 1'b1;
            end
            sme_pkg::S_ALU: n_state = sme_pkg::S_WAIT;
            sme_pkg::S_WAIT: begin
                if (alu_rsp.done) begin
                    wr_en = 1'b1;
                    wr_addr = AW'(r_depth - DW'(2));
                    wr_data = alu_res;
                    n_depth = dm1;
                    n_ov = 1'b1;
                    n_state = sme_pkg::S_OUT;
                end
            end
            sme_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_ov = 1'b0;
                    n_state = sme_pkg::S_IDLE;
                end
            end
            default: n_state = sme_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != sme_pkg::S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data = r_out;

    a_ov_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_state == sme_pkg::S_OUT)
        else $error("result valid outside output state");
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= STACK_DEPTH)
        else $error("stack depth beyond capacity");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_halt) && $past(i_rst_n) |-> r_halt)
        else $error("halt cleared without reset");
    a_halted_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && $past(r_halt) && $rose(r_ov) |-> r_out.status == sme_pkg::ST_HALTED)
        else $error("halted item not answered halted");

endmodule
`default_nettype wire

// File: dv/tb_stack_machine_execute_core.sv
// Self-checking testbench for the stack machine execute core: directed and random programs.
`default_nettype none
module tb_stack_machine_execute_core;

    localparam int STK_DEPTH  = 1024;
    localparam int PROG_DEPTH = sme_pkg::PROGRAM_DEPTH;
    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    sme_pkg::t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    sme_pkg::t_out_item o_out_data;

    stack_machine_execute_core #(
        .STACK_DEPTH(STK_DEPTH)
    ) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow machine state.
    logic [31:0] shadow_stack [STK_DEPTH];
    int          shadow_depth;
    logic [31:0] shadow_regs [5];
    logic        shadow_eq;
    logic [31:0] shadow_cell;
    logic        shadow_cell_ok;
    logic        shadow_halted;

    sme_pkg::t_in_item  pending_instrs [$];
    sme_pkg::t_out_item expected_results [$];
    int        gap_left;
    int        stall_left;
    int        cycle_count;
    int        fail_count;
    logic      drain_hold;

    // Accept status captured at the rising edge so the driver sees one consistent view.
    logic o_in_stall_q = 1'b1;

    function automatic logic [31:0] reg_get(logic [2:0] sel);
        return (sel < 5) ? shadow_regs[sel] : 32'd0;
    endfunction

    function automatic void shadow_reset();
        shadow_depth = 0;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        shadow_eq = 1'b0;
        shadow_cell = '0;
        shadow_cell_ok = 1'b0;
        shadow_halted = 1'b0;
    endfunction

    function automatic logic [31:0] signed_quotient(logic [31:0] a, logic [31:0] b);
        logic [31:0] ua, ub, q;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic sme_pkg::t_out_item execute_instr(sme_pkg::t_in_item it);
        sme_pkg::t_out_item r;
        sme_pkg::t_status   st;
        logic [1:0]  mode;
        logic [31:0] t, s, v, other;
        r = '0;
        st = sme_pkg::ST_OK;
        mode = it.operand_mode;
        if (shadow_halted) begin
            r.status = sme_pkg::ST_HALTED;
            return r;
        end
        case (it.func)
            sme_pkg::OP_PSH, sme_pkg::OP_POR, sme_pkg::OP_LD: begin
                if (shadow_depth >= STK_DEPTH) st = sme_pkg::ST_OVER;
                else if (it.func == sme_pkg::OP_PSH) begin
                    shadow_stack[shadow_depth++] = it.imm;
                end else if (it.func == sme_pkg::OP_POR) begin
                    shadow_stack[shadow_depth++] = reg_get(it.dst_sel);
                    if (it.dst_sel < 5) shadow_regs[it.dst_sel] = '0;
                end else if (!shadow_cell_ok) st = sme_pkg::ST_NOCELL;
                else shadow_stack[shadow_depth++] = shadow_cell;
            end
            sme_pkg::OP_POP: begin
                if (shadow_depth < 1) st = sme_pkg::ST_UNDER;
                else shadow_regs[2] = shadow_stack[--shadow_depth];
            end
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
                if (shadow_depth < 2) st = sme_pkg::ST_UNDER;
                else begin
                    t = shadow_stack[shadow_depth-1];
                    s = shadow_stack[shadow_depth-2];
                    case (it.func)
                        sme_pkg::OP_ADD: v = s + t;
                        sme_pkg::OP_SUB: v = s - t;
                        sme_pkg::OP_MUL: v = s * t;
                        default: v = (t == 0) ? 32'd0 : signed_quotient(s, t);
                    endcase
                    if (it.func == sme_pkg::OP_DIV && t == 0) st = sme_pkg::ST_DIVZ;
                    else begin
                        shadow_depth--;
                        shadow_stack[shadow_depth-1] = v;
                    end
                end
            end
            sme_pkg::OP_MOV: begin
                if (mode == sme_pkg::MODE_STACK) begin
                    if (shadow_depth < 1) st = sme_pkg::ST_UNDER;
                    else begin
                        v = shadow_stack[--shadow_depth];
                        if (it.dst_sel < 5) shadow_regs[it.dst_sel] = v;
                    end
                end else begin
                    v = (mode == sme_pkg::MODE_IMM) ? it.imm : reg_get(it.src_sel);
                    if (it.dst_sel < 5) shadow_regs[it.dst_sel] = v;
                end
            end
            sme_pkg::OP_CMP: begin
                if (mode == sme_pkg::MODE_STACK && shadow_depth < 1) st = sme_pkg::ST_UNDER;
                else begin
                    other = (mode == sme_pkg::MODE_STACK) ? shadow_stack[shadow_depth-1] :
                            (mode == sme_pkg::MODE_IMM) ? it.imm : reg_get(it.src_sel);
                    shadow_eq = (reg_get(it.dst_sel) == other);
                end
            end
            sme_pkg::OP_JMP: r.branch_taken = 1'b1;
            sme_pkg::OP_JIE: r.branch_taken = shadow_eq;
            sme_pkg::OP_JNE: r.branch_taken = !shadow_eq;
            sme_pkg::OP_ALC: begin
                shadow_cell_ok = 1'b1;
                shadow_cell = '0;
            end
            sme_pkg::OP_FRE: shadow_cell_ok = 1'b0;
            sme_pkg::OP_ST: begin
                if (shadow_depth < 1) st = sme_pkg::ST_UNDER;
                else if (!shadow_cell_ok) st = sme_pkg::ST_NOCELL;
                else shadow_cell = shadow_stack[--shadow_depth];
            end
            sme_pkg::OP_MSG: begin
                if (shadow_depth < 1) st = sme_pkg::ST_UNDER;
                else begin
                    r.shown_valid = 1'b1;
                    r.shown_value = shadow_stack[shadow_depth-1];
                end
            end
            default: st = sme_pkg::ST_HALTED;
        endcase
        if (st != sme_pkg::ST_OK) shadow_halted = 1'b1;
        r.status = st;
        if (r.branch_taken) r.branch_target = 10'(it.jump_target % PROG_DEPTH);
        return r;
    endfunction

    function automatic sme_pkg::t_in_item make_instr(sme_pkg::t_op op, logic [31:0] imm,
                                                     logic [2:0] d, logic [2:0] s,
                                                     logic [1:0] m, logic [9:0] j);
        sme_pkg::t_in_item it;
        it.func = op;
        it.imm = imm;
        it.dst_sel = d;
        it.src_sel = s;
        it.operand_mode = m;
        it.jump_target = j;
        return it;
    endfunction

    function automatic sme_pkg::t_in_item random_instr(sme_pkg::t_op op);
        logic [31:0] imm;
        case ($urandom_range(0, 5))
            0: imm = 32'h8000_0000;
            1: imm = 32'h7fff_ffff;
            2: imm = 32'hffff_ffff;
            3: imm = $urandom_range(0, 4);
            default: imm = $urandom;
        endcase
        return make_instr(op, imm, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          2'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)));
    endfunction

    // Ops that keep the machine running; the random part mostly draws from these.
    function automatic sme_pkg::t_op safe_op();
        sme_pkg::t_op ops [14];
        ops = '{sme_pkg::OP_PSH, sme_pkg::OP_POP, sme_pkg::OP_POR, sme_pkg::OP_ADD,
                sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV, sme_pkg::OP_MOV,
                sme_pkg::OP_CMP, sme_pkg::OP_JMP, sme_pkg::OP_JIE, sme_pkg::OP_JNE,
                sme_pkg::OP_ALC, sme_pkg::OP_MSG};
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? sme_pkg::OP_ST : sme_pkg::OP_LD;
        if ($urandom_range(0, 19) == 0) return sme_pkg::OP_FRE;
        return ops[$urandom_range(0, 13)];
    endfunction

    // Driver: presents queued instructions with random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall_q) begin
                i_in_valid <= 1'b0;
            end else if (!i_in_valid && pending_instrs.size() > 0 && !drain_hold) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                else begin
                    i_in_data <= pending_instrs.pop_front();
                    i_in_valid <= 1'b1;
                    gap_left <= $urandom_range(0, 10) * $urandom_range(0, 1);
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each input transfer, checks each output transfer.
    always @(posedge i_clk) begin
        sme_pkg::t_out_item exp_r;
        cycle_count <= cycle_count + 1;
        o_in_stall_q <= o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(execute_instr(i_in_data));
            end
            if (o_out_valid && !i_out_stall) begin
                if ($urandom_range(0, 2) == 0) stall_left <= $urandom_range(0, 10);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_data);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_out_data.status !== exp_r.status ||
                        o_out_data.branch_taken !== exp_r.branch_taken ||
                        o_out_data.branch_target !== exp_r.branch_target ||
                        o_out_data.shown_valid !== exp_r.shown_valid ||
                        o_out_data.shown_value !== exp_r.shown_value) begin
                        $display("%0t: mismatch expected %p actual %p",
                                 $time, exp_r, o_out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("stack_machine_execute_core regression: fail");
            $finish;
        end
    end

    // Builds one random program segment on the live machine; there is no reset between
    // segments, so a halt in one segment carries over into the later ones.
    task automatic queue_program(int count);
        int depth_guess;
        sme_pkg::t_op op;
        depth_guess = 0;
        for (int i = 0; i < count; i++) begin
            op = safe_op();
            // Keep the stack fed so stack-consuming ops mostly succeed.
            if (depth_guess < 3 && $urandom_range(0, 2) != 0) op = sme_pkg::OP_PSH;
            if (op == sme_pkg::OP_DIV) begin
                pending_instrs.push_back(random_instr(sme_pkg::OP_PSH));
                pending_instrs[$].imm = ($urandom_range(0, 1) ? 32'hffff_ffff :
                                         32'd1 + $urandom_range(0, 1000));
                depth_guess++;
            end
            if ((op == sme_pkg::OP_ST || op == sme_pkg::OP_LD) && $urandom_range(0, 3) != 0)
            begin
                pending_instrs.push_back(random_instr(sme_pkg::OP_ALC));
            end
            pending_instrs.push_back(random_instr(op));
            case (op)
                sme_pkg::OP_PSH, sme_pkg::OP_POR, sme_pkg::OP_LD: depth_guess++;
                sme_pkg::OP_POP, sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
                sme_pkg::OP_DIV, sme_pkg::OP_ST: depth_guess--;
                default: ;
            endcase
            if (depth_guess < 0) depth_guess = 0;
        end
    endtask

    task automatic wait_drained();
        while (pending_instrs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        gap_left = 0;
        stall_left = 0;
        drain_hold = 1'b0;
        shadow_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, each op but HLT, divide wrap, cell handling, register selects.
        pending_instrs.push_back(make_instr(sme_pkg::OP_POR, 32'd0, 3'd7, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_FRE, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_MOV, 32'h8000_0000, 3'd0, 3'd0, 2'd1,
                                            10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_MOV, 32'd0, 3'd1, 3'd0, 2'd3, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_CMP, 32'd0, 3'd1, 3'd0, 2'd2, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_JIE, 32'd0, 3'd0, 3'd0, 2'd0,
                                            10'd1023));
        pending_instrs.push_back(make_instr(sme_pkg::OP_JNE, 32'd0, 3'd0, 3'd0, 2'd0, 10'd5));
        pending_instrs.push_back(make_instr(sme_pkg::OP_JMP, 32'hffff_ffff, 3'd7, 3'd7, 2'd3,
                                            10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_PSH, 32'h8000_0000, 3'd0, 3'd0, 2'd0,
                                            10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_PSH, 32'hffff_ffff, 3'd0, 3'd0, 2'd0,
                                            10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_DIV, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_MSG, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_CMP, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_PSH, 32'h7fff_ffff, 3'd0, 3'd0, 2'd0,
                                            10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_MUL, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_ALC, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_ST, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_LD, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_POP, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_FRE, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_MOV, 32'd0, 3'd5, 3'd6, 2'd2, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_PSH, 32'd3, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_PSH, 32'd7, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_SUB, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        pending_instrs.push_back(make_instr(sme_pkg::OP_ADD, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));

        // Random program on the live machine; the sender pauses for a full drain midway.
        queue_program(30);
        wait_drained();
        drain_hold = 1'b1;
        repeat (40) @(posedge i_clk);
        drain_hold = 1'b0;
        queue_program(30);
        wait_drained();

        // Stack to full, then overflow.
        for (int i = 0; i < STK_DEPTH + 2; i++) begin
            pending_instrs.push_back(random_instr(sme_pkg::OP_PSH));
            pending_instrs[$].func = (i % 7 == 3) ? sme_pkg::OP_POR : sme_pkg::OP_PSH;
        end
        pending_instrs.push_back(make_instr(sme_pkg::OP_MSG, 32'd0, 3'd0, 3'd0, 2'd0, 10'd0));
        // Everything after a halt is ignored, including unknown opcodes.
        for (int i = 0; i < 20; i++) begin
            pending_instrs.push_back(random_instr(sme_pkg::OP_PSH));
            pending_instrs[$].func = 5'($urandom_range(0, 31));
        end
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("stack_machine_execute_core regression: pass");
        end else begin
            $display("stack_machine_execute_core regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
design/sme_pkg.sv
design/sme_alu.sv
design/stack_machine_execute_core.sv
dv/tb_stack_machine_execute_core.sv
